// ===== hw/rtl/wch_pkg.sv =====
// Shared types and constants for the windowed texture-code histogram.
package wch_pkg;

  // Operation codes carried by an input word.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Field widths fixed by the interface.
  localparam int OP_W    = 2;
  localparam int CODE_W  = 9;
  localparam int IDX_W   = 8;
  localparam int OUT_W   = 25;
  localparam int DIM_W   = 13;
  localparam int POSR_W  = 12;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Register indexes within the configuration space.
  localparam logic [2:0] REG_MAP_WIDTH = 3'd0;
  localparam logic [2:0] REG_WIN_X     = 3'd1;
  localparam logic [2:0] REG_WIN_Y     = 3'd2;
  localparam logic [2:0] REG_WIN_W     = 3'd3;
  localparam logic [2:0] REG_WIN_H     = 3'd4;

  // Register reset values.
  localparam logic [DIM_W-1:0]  RST_MAP_WIDTH = 13'd64;
  localparam logic [POSR_W-1:0] RST_WIN_X     = 12'd0;
  localparam logic [POSR_W-1:0] RST_WIN_Y     = 12'd0;
  localparam logic [DIM_W-1:0]  RST_WIN_W     = 13'd64;
  localparam logic [DIM_W-1:0]  RST_WIN_H     = 13'd64;

  // Per-word commands from the pipeline control to the bin store.
  typedef struct packed {
    logic rd_en;  // a word enters the pipeline; fetch its bin
    logic inc;    // the word in the count stage bumps its bin
    logic clr;    // the word in the count stage clears every bin
  } wch_ctl_t;

endpackage

// ===== hw/rtl/wch_bin_store.sv =====
// Histogram bin memory with valid flags, write forwarding and saturating increment.
module wch_bin_store #(
  parameter int NUM_BINS   = 256,
  parameter int COUNT_BITS = 25
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wch_pkg::wch_ctl_t            ctl,
  input  logic [$clog2(NUM_BINS)-1:0]  rd_addr,
  input  logic [$clog2(NUM_BINS)-1:0]  s1_addr,
  output logic [COUNT_BITS-1:0]        cur_count
);
  import wch_pkg::*;

  localparam int BIN_W = $clog2(NUM_BINS);

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]   vld_r;
  logic [COUNT_BITS-1:0] rdata_r;
  logic                  rvld_r;
  logic                  last_wr_r;
  logic                  last_clr_r;
  logic [BIN_W-1:0]      last_addr_r;
  logic [COUNT_BITS-1:0] last_data_r;
  logic [COUNT_BITS-1:0] count_nxt;

  // Registered read of the bin and its valid flag when a word is accepted.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= vld_r[rd_addr];
    end
  end

  // Bin write from the count stage.
  always_ff @(posedge clk) begin
    if (ctl.inc) begin
      mem[s1_addr] <= count_nxt;
    end
  end

  // Valid flags: an unwritten or cleared bin reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.inc) begin
      vld_r[s1_addr] <= 1'b1;
    end
  end

  // Most recent store action, forwarded over the read that shared its edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_wr_r  <= 1'b0;
      last_clr_r <= 1'b0;
    end else if (ctl.clr) begin
      last_wr_r  <= 1'b0;
      last_clr_r <= 1'b1;
    end else if (ctl.inc) begin
      last_wr_r  <= 1'b1;
      last_clr_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.inc) begin
      last_addr_r <= s1_addr;
      last_data_r <= count_nxt;
    end
  end

  // Resolve the current count of the bin in the count stage.
  always_comb begin
    if (last_clr_r) begin
      cur_count = '0;
    end else if (last_wr_r && (last_addr_r == s1_addr)) begin
      cur_count = last_data_r;
    end else if (rvld_r) begin
      cur_count = rdata_r;
    end else begin
      cur_count = '0;
    end
  end

  // Saturating increment: a full bin stays full.
  assign count_nxt = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);

endmodule

// ===== hw/rtl/window_code_histogram.sv =====
// Top level of the windowed texture-code histogram.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_op, in_code, in_first_of_map, in_bin_index
//   out_     output     out_valid / out_stall out_bin_count
//   config   input      psel/penable/pready   paddr, pwdata, prdata
//
// One word is accepted per clock while in_stall is low. A read word's count goes from the
// count stage to the output register; add and clear words finish there and return nothing.
// The rate is set by the single read/write port pair of the bin memory, with the
// write of one word forwarded to the read of the next.
// Reset clears all bins at once through per-bin valid flags; no clearing pass.
// in_stall rises only while a read word waits behind a stalled, full output register.
module window_code_histogram #(
  parameter int NUM_BINS   = 256,
  parameter int MAX_DIM    = 4096,
  parameter int COUNT_BITS = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wch_pkg::OP_W-1:0]          in_op,
  input  logic signed [wch_pkg::CODE_W-1:0] in_code,
  input  logic                              in_first_of_map,
  input  logic [wch_pkg::IDX_W-1:0]         in_bin_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wch_pkg::OUT_W-1:0]         out_bin_count,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wch_pkg::PADDR_W-1:0]       paddr,
  input  logic [wch_pkg::PDATA_W-1:0]       pwdata,
  output logic [wch_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import wch_pkg::*;

  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int ADDR_EXT = (BIN_W > IDX_W) ? BIN_W : IDX_W;
  localparam int POS_W    = $clog2(MAX_DIM);
  localparam int CMP_W    = ((POS_W > DIM_W) ? POS_W : DIM_W) + 2;
  localparam int CNT_EXT  = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
  localparam logic [CMP_W-1:0] MAX_C   = CMP_W'(MAX_DIM);
  localparam logic [POS_W-1:0] POS_TOP = POS_W'(MAX_DIM - 1);

  // Configuration registers.
  logic [DIM_W-1:0]  map_width_r;
  logic [POSR_W-1:0] win_x_r;
  logic [POSR_W-1:0] win_y_r;
  logic [DIM_W-1:0]  win_w_r;
  logic [DIM_W-1:0]  win_h_r;
  logic              cfg_wr;

  // Position and pipeline state.
  logic [POS_W-1:0]  col_r, row_r, col_nxt, row_nxt, col_cur, row_cur;
  logic              s1_valid_r, s1_inc_r, s1_oob_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [BIN_W-1:0]  s1_addr_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_bin_count_r;

  logic              in_fire, s1_pop, out_free;
  logic [CMP_W-1:0]  col_c, row_c, x_end, y_end, map_c, eff_w;
  logic              in_win, code_ok, idx_ok, col_wrap, add_inc;
  logic [ADDR_EXT-1:0] code_ext, idx_ext;
  logic [BIN_W-1:0]  addr_sel;
  logic [COUNT_BITS-1:0] cur_count;
  logic [CNT_EXT-1:0]    cnt_ext;
  wch_ctl_t          ctl;

  // Configuration port: writes on the access cycle, reads are combinational.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r <= RST_MAP_WIDTH;
      win_x_r     <= RST_WIN_X;
      win_y_r     <= RST_WIN_Y;
      win_w_r     <= RST_WIN_W;
      win_h_r     <= RST_WIN_H;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MAP_WIDTH: map_width_r <= pwdata[DIM_W-1:0];
        REG_WIN_X:     win_x_r     <= pwdata[POSR_W-1:0];
        REG_WIN_Y:     win_y_r     <= pwdata[POSR_W-1:0];
        REG_WIN_W:     win_w_r     <= pwdata[DIM_W-1:0];
        REG_WIN_H:     win_h_r     <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MAP_WIDTH: prdata = PDATA_W'(map_width_r);
      REG_WIN_X:     prdata = PDATA_W'(win_x_r);
      REG_WIN_Y:     prdata = PDATA_W'(win_y_r);
      REG_WIN_W:     prdata = PDATA_W'(win_w_r);
      REG_WIN_H:     prdata = PDATA_W'(win_h_r);
      default:       prdata = '0;
    endcase
  end

  // Handshake: only a read waiting on a full, stalled output holds the pipeline.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_pop   = s1_valid_r && ((s1_op_r != OP_READ) || out_free);
  assign in_stall = s1_valid_r && !s1_pop;
  assign in_fire  = in_valid && !in_stall;

  // Position of the incoming code and the window test.
  assign col_cur = in_first_of_map ? '0 : col_r;
  assign row_cur = in_first_of_map ? '0 : row_r;
  assign col_c   = CMP_W'(col_cur);
  assign row_c   = CMP_W'(row_cur);
  assign x_end   = CMP_W'(win_x_r) + CMP_W'(win_w_r);
  assign y_end   = CMP_W'(win_y_r) + CMP_W'(win_h_r);
  assign in_win  = (col_c >= CMP_W'(win_x_r)) && (col_c < x_end) &&
                   (row_c >= CMP_W'(win_y_r)) && (row_c < y_end);

  // Effective map width, clamped to one and to the largest dimension.
  assign map_c = CMP_W'(map_width_r);
  always_comb begin
    if (map_c == '0) begin
      eff_w = CMP_W'(1);
    end else if (map_c > MAX_C) begin
      eff_w = MAX_C;
    end else begin
      eff_w = map_c;
    end
  end

  // Raster step: the column wraps at the map width, the row at the largest dimension.
  assign col_wrap = (col_c + CMP_W'(1)) >= eff_w;
  always_comb begin
    if (col_wrap) begin
      col_nxt = '0;
      row_nxt = (row_cur == POS_TOP) ? '0 : row_cur + POS_W'(1);
    end else begin
      col_nxt = col_cur + POS_W'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire && (in_op == OP_ADD)) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Bin selection: padding codes and codes past the last bin are skipped.
  assign code_ok  = !in_code[CODE_W-1] && (32'(in_code[CODE_W-2:0]) < 32'(NUM_BINS));
  assign idx_ok   = 32'(in_bin_index) < 32'(NUM_BINS);
  assign code_ext = ADDR_EXT'(in_code[CODE_W-2:0]);
  assign idx_ext  = ADDR_EXT'(in_bin_index);
  assign add_inc  = (in_op == OP_ADD) && code_ok && in_win;

  always_comb begin
    addr_sel = '0;
    case (in_op)
      OP_ADD:  if (code_ok) addr_sel = code_ext[BIN_W-1:0];
      OP_READ: if (idx_ok)  addr_sel = idx_ext[BIN_W-1:0];
      default: addr_sel = '0;
    endcase
  end

  // Count stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_pop) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_op;
      s1_inc_r  <= add_inc;
      s1_oob_r  <= !idx_ok;
      s1_addr_r <= addr_sel;
    end
  end

  // Bin store commands.
  assign ctl.rd_en = in_fire;
  assign ctl.inc   = s1_pop && (s1_op_r == OP_ADD) && s1_inc_r;
  assign ctl.clr   = s1_pop && (s1_op_r == OP_CLEAR);

  wch_bin_store #(
    .NUM_BINS  (NUM_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_addr  (addr_sel),
    .s1_addr  (s1_addr_r),
    .cur_count(cur_count)
  );

  // Output register: loads a read result, empties when the word is taken.
  assign cnt_ext = CNT_EXT'(cur_count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_pop && (s1_op_r == OP_READ)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_pop && (s1_op_r == OP_READ)) begin
      out_bin_count_r <= s1_oob_r ? '0 : cnt_ext[OUT_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_count = out_bin_count_r;

endmodule

// ===== hw/rtl/wch_checker.sv =====
// Port-level checks for the windowed texture-code histogram, bound to the top level.
module wch_port_checks (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [wch_pkg::OP_W-1:0]  in_op,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [wch_pkg::OUT_W-1:0] out_bin_count
);
  import wch_pkg::*;

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bin_count))
    else $error("result word changed while stalled");

  // The input side stalls only behind a full, stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // A fresh result follows an accepted read word.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && (in_op == OP_READ), 2))
    else $error("result word without a matching read");

endmodule

bind window_code_histogram wch_port_checks u_wch_checker (.*);
